[hdl/imhdk_pkg.sv]
package imhdk_pkg;

    // Default sizing
    localparam int MAX_NODES_DEF = 1024;
    localparam int DIST_BITS_DEF = 32;

    // Fixed field widths
    localparam int NODE_W  = 10;
    localparam int COUNT_W = 11;
    localparam int NDIST_W = 32;
    localparam int FUNC_W  = 2;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_INIT     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_EXTRACT  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DECREASE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY    = 2'd3;

    // Register map
    localparam logic REG_NODE_COUNT  = 1'b0;
    localparam logic REG_SOURCE_NODE = 1'b1;

    localparam logic [COUNT_W-1:0] NODE_COUNT_RST  = 11'd1024;
    localparam logic [NODE_W-1:0]  SOURCE_NODE_RST = 10'd0;

    // Result bundle from the sequencer to the output register
    typedef struct packed {
        logic [NODE_W-1:0] min_node;
        logic              found;
        logic              in_heap;
        logic              heap_empty;
        logic              status;
    } result_t;

endpackage

[hdl/indexed_min_heap_decrease_key_core.sv]
// Indexed binary min-heap with decrease-key, a priority queue for shortest-path search.
// Input channel s_*: one item per transfer, s_func selects initialize, extract minimum,
// decrease key or membership query. Result channel m_*: exactly one result per item.
// Configuration: APB write of node_count (offset 0) and source_node (offset 4); the
// user must write only while the block is idle; the block does not enforce it. Reads
// return the register values, pready is tied high. Items are processed one at a time;
// s_ready is high while the sequencer is idle. Processing time from the input transfer
// to m_valid is set by the single read port of each of the three heap memories (order,
// position, distance) and the one-level-per-pass sift loop:
//   initialize      one memory entry per cycle over all entries, then sift up
//   extract minimum two child reads and one write-back per level
//   decrease key    sift up from the node's slot; membership query no sift
// The next item is taken in the cycle after its predecessor's result is registered.
// Reset clears the heap size (heap empty) and loads node_count 1024, source_node 0;
// memory contents are undefined until the first initialize.
// A finished result sits in the output register until m_ready; the block takes the
// next item meanwhile and holds its result back until the register frees up.
module indexed_min_heap_decrease_key_core #(
    parameter int MAX_NODES = imhdk_pkg::MAX_NODES_DEF,
    parameter int DIST_BITS = imhdk_pkg::DIST_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [imhdk_pkg::FUNC_W-1:0]  s_func,
    input  logic [imhdk_pkg::NODE_W-1:0]  s_node,
    input  logic [imhdk_pkg::NDIST_W-1:0] s_new_distance,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [imhdk_pkg::NODE_W-1:0]  m_min_node,
    output logic                          m_found,
    output logic                          m_in_heap,
    output logic                          m_heap_empty,
    output logic                          m_status,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [imhdk_pkg::COUNT_W-1:0] node_count_reg;
    logic [imhdk_pkg::NODE_W-1:0]  source_node_reg;
    logic                          m_valid_reg;
    imhdk_pkg::result_t            out_reg;
    imhdk_pkg::result_t            res;
    logic                          res_valid;
    logic                          res_ready;
    logic                          idle;

    assign pready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg  <= imhdk_pkg::NODE_COUNT_RST;
            source_node_reg <= imhdk_pkg::SOURCE_NODE_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == imhdk_pkg::REG_SOURCE_NODE) begin
                source_node_reg <= pwdata[imhdk_pkg::NODE_W-1:0];
            end else begin
                node_count_reg <= pwdata[imhdk_pkg::COUNT_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == imhdk_pkg::REG_SOURCE_NODE) ? 32'(source_node_reg)
                                                             : 32'(node_count_reg);

    imhdk_ctrl #(.MAX_NODES(MAX_NODES), .DIST_BITS(DIST_BITS)) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (s_valid && s_ready),
        .func         (s_func),
        .node         (s_node),
        .new_distance (s_new_distance),
        .node_count   (node_count_reg),
        .source_node  (source_node_reg),
        .idle         (idle),
        .res_ready    (res_ready),
        .res_valid    (res_valid),
        .res          (res)
    );

    assign s_ready   = idle;
    assign res_ready = !m_valid_reg || m_ready;

    // Output register: load on a new result, drop valid after the transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_min_node   = out_reg.min_node;
    assign m_found      = out_reg.found;
    assign m_in_heap    = out_reg.in_heap;
    assign m_heap_empty = out_reg.heap_empty;
    assign m_status     = out_reg.status;

endmodule

[hdl/imhdk_ram.sv]
module imhdk_ram #(
    parameter int DEPTH = imhdk_pkg::MAX_NODES_DEF,
    parameter int WIDTH = imhdk_pkg::NODE_W
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

[hdl/imhdk_ctrl.sv]
module imhdk_ctrl #(
    parameter int MAX_NODES = imhdk_pkg::MAX_NODES_DEF,
    parameter int DIST_BITS = imhdk_pkg::DIST_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [imhdk_pkg::FUNC_W-1:0]     func,
    input  logic [imhdk_pkg::NODE_W-1:0]     node,
    input  logic [imhdk_pkg::NDIST_W-1:0]    new_distance,
    input  logic [imhdk_pkg::COUNT_W-1:0]    node_count,
    input  logic [imhdk_pkg::NODE_W-1:0]     source_node,
    output logic                             idle,
    input  logic                             res_ready,
    output logic                             res_valid,
    output imhdk_pkg::result_t               res
);

    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int SW = $clog2(MAX_NODES + 1);
    localparam int LW = IW + 2;
    localparam logic [DIST_BITS-1:0] DIST_INF = '1;
    localparam logic [IW-1:0] LAST_SLOT = IW'(MAX_NODES - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_INIT, S_INIT_SRC, S_EX_B, S_EX_C, S_EX_D,
        S_DK_A, S_Q_A,
        S_UP_CHK, S_UP_B, S_UP_C, S_UP_FIN,
        S_DN_L, S_DN_LB, S_DN_LC, S_DN_RB, S_DN_RC, S_DN_MV, S_DN_FIN,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [SW-1:0] size_reg, size_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] sweep_reg, sweep_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic [IW-1:0] cur_node_reg, cur_node_next;
    logic [DIST_BITS-1:0] cur_key_reg, cur_key_next;
    logic [IW-1:0] pnode_reg, pnode_next;
    logic [IW-1:0] best_reg, best_next;
    logic [IW-1:0] best_node_reg, best_node_next;
    logic [DIST_BITS-1:0] best_key_reg, best_key_next;
    logic moved_reg, moved_next;
    logic [IW-1:0] root_reg, root_next;
    logic [IW-1:0] node_reg, node_next;
    logic [DIST_BITS-1:0] ndist_reg, ndist_next;
    imhdk_pkg::result_t res_reg, res_next;

    logic ord_we, pos_we, dist_we;
    logic [IW-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rdata;
    logic [IW-1:0] pos_waddr, pos_wdata, pos_raddr, pos_rdata;
    logic [IW-1:0] dist_waddr, dist_raddr;
    logic [DIST_BITS-1:0] dist_wdata, dist_rdata;

    logic [LW-1:0] left_w, right_w;
    logic          node_ok;
    logic [31:0]   cnt_w;
    logic [DIST_BITS-1:0] nd_sat;

    imhdk_ram #(.DEPTH(MAX_NODES), .WIDTH(IW)) u_order (
        .aclk(aclk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
        .raddr(ord_raddr), .rdata(ord_rdata)
    );
    imhdk_ram #(.DEPTH(MAX_NODES), .WIDTH(IW)) u_pos (
        .aclk(aclk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
        .raddr(pos_raddr), .rdata(pos_rdata)
    );
    imhdk_ram #(.DEPTH(MAX_NODES), .WIDTH(DIST_BITS)) u_dist (
        .aclk(aclk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
        .raddr(dist_raddr), .rdata(dist_rdata)
    );

    // Child slots of the current slot
    assign left_w  = {1'b0, slot_reg, 1'b1};
    assign right_w = left_w + LW'(1);

    // Range check, count clamp and distance saturation of the incoming item
    assign node_ok = 32'(node) < 32'(MAX_NODES);
    always_comb begin
        cnt_w = 32'(node_count);
        if (cnt_w == 32'd0) begin
            cnt_w = 32'd1;
        end else if (cnt_w > 32'(MAX_NODES)) begin
            cnt_w = 32'(MAX_NODES);
        end
        nd_sat = (64'(new_distance) > 64'(DIST_INF)) ? DIST_INF : DIST_BITS'(new_distance);
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT) && res_ready;

    // Report emptiness from the settled heap size
    always_comb begin
        res            = res_reg;
        res.heap_empty = (size_reg == '0);
    end

    // Sequencer: read, compare, write back one heap level at a time
    always_comb begin
        state_next     = state_reg;
        size_next      = size_reg;
        cnt_next       = cnt_reg;
        sweep_next     = sweep_reg;
        slot_next      = slot_reg;
        cur_node_next  = cur_node_reg;
        cur_key_next   = cur_key_reg;
        pnode_next     = pnode_reg;
        best_next      = best_reg;
        best_node_next = best_node_reg;
        best_key_next  = best_key_reg;
        moved_next     = moved_reg;
        root_next      = root_reg;
        node_next      = node_reg;
        ndist_next     = ndist_reg;
        res_next       = res_reg;
        ord_we = 1'b0; ord_waddr = slot_reg; ord_wdata = cur_node_reg; ord_raddr = '0;
        pos_we = 1'b0; pos_waddr = cur_node_reg; pos_wdata = slot_reg; pos_raddr = node_reg;
        dist_we = 1'b0; dist_waddr = node_reg; dist_wdata = ndist_reg; dist_raddr = '0;

        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    res_next   = '0;
                    node_next  = IW'(node);
                    ndist_next = nd_sat;
                    case (func)
                        imhdk_pkg::FUNC_INIT: begin
                            cnt_next   = SW'(cnt_w);
                            sweep_next = '0;
                            state_next = S_INIT;
                        end
                        imhdk_pkg::FUNC_EXTRACT: begin
                            ord_raddr  = '0;
                            state_next = (size_reg == '0) ? S_OUT : S_EX_B;
                        end
                        imhdk_pkg::FUNC_DECREASE: begin
                            pos_raddr = IW'(node);
                            if (node_ok) begin
                                state_next = S_DK_A;
                            end else begin
                                res_next.status = 1'b1;
                                state_next      = S_OUT;
                            end
                        end
                        default: begin
                            pos_raddr  = IW'(node);
                            state_next = node_ok ? S_Q_A : S_OUT;
                        end
                    endcase
                end
            end
            // Load identity order and infinite distances
            S_INIT: begin
                ord_we = 1'b1; ord_waddr = sweep_reg; ord_wdata = sweep_reg;
                pos_we = 1'b1; pos_waddr = sweep_reg; pos_wdata = sweep_reg;
                dist_we = 1'b1; dist_waddr = sweep_reg; dist_wdata = DIST_INF;
                sweep_next = sweep_reg + IW'(1);
                if (sweep_reg == LAST_SLOT) begin
                    state_next = S_INIT_SRC;
                end
            end
            S_INIT_SRC: begin
                size_next = cnt_reg;
                if (32'(source_node) < 32'(cnt_reg)) begin
                    dist_we       = 1'b1;
                    dist_waddr    = IW'(source_node);
                    dist_wdata    = '0;
                    cur_node_next = IW'(source_node);
                    cur_key_next  = '0;
                    slot_next     = IW'(source_node);
                    state_next    = S_UP_CHK;
                end else begin
                    state_next = S_OUT;
                end
            end
            // Extract: take root, fetch last entry
            S_EX_B: begin
                root_next         = ord_rdata;
                res_next.min_node = imhdk_pkg::NODE_W'(ord_rdata);
                res_next.found    = 1'b1;
                ord_raddr         = IW'(size_reg - SW'(1));
                state_next        = S_EX_C;
            end
            S_EX_C: begin
                cur_node_next = ord_rdata;
                dist_raddr    = ord_rdata;
                ord_we = 1'b1; ord_waddr = IW'(size_reg - SW'(1)); ord_wdata = root_reg;
                pos_we = 1'b1; pos_waddr = root_reg; pos_wdata = IW'(size_reg - SW'(1));
                size_next  = size_reg - SW'(1);
                slot_next  = '0;
                state_next = S_EX_D;
            end
            S_EX_D: begin
                cur_key_next = dist_rdata;
                state_next   = S_DN_L;
            end
            // Decrease key: check membership, write distance
            S_DK_A: begin
                if (32'(pos_rdata) < 32'(size_reg)) begin
                    dist_we       = 1'b1;
                    cur_node_next = node_reg;
                    cur_key_next  = ndist_reg;
                    slot_next     = pos_rdata;
                    state_next    = S_UP_CHK;
                end else begin
                    res_next.status = 1'b1;
                    state_next      = S_OUT;
                end
            end
            S_Q_A: begin
                res_next.in_heap = 32'(pos_rdata) < 32'(size_reg);
                state_next       = S_OUT;
            end
            // Sift up: move parents down into the hole
            S_UP_CHK: begin
                ord_raddr  = (slot_reg - IW'(1)) >> 1;
                state_next = (slot_reg == '0) ? S_UP_FIN : S_UP_B;
            end
            S_UP_B: begin
                pnode_next = ord_rdata;
                dist_raddr = ord_rdata;
                state_next = S_UP_C;
            end
            S_UP_C: begin
                if (cur_key_reg < dist_rdata) begin
                    ord_we = 1'b1; ord_waddr = slot_reg; ord_wdata = pnode_reg;
                    pos_we = 1'b1; pos_waddr = pnode_reg; pos_wdata = slot_reg;
                    slot_next  = (slot_reg - IW'(1)) >> 1;
                    state_next = S_UP_CHK;
                end else begin
                    state_next = S_UP_FIN;
                end
            end
            S_UP_FIN, S_DN_FIN: begin
                ord_we = 1'b1;
                pos_we = 1'b1;
                state_next = S_OUT;
            end
            // Sift down: left child, then right child, strict less
            S_DN_L: begin
                ord_raddr     = IW'(left_w);
                best_next     = slot_reg;
                best_key_next = cur_key_reg;
                moved_next    = 1'b0;
                state_next    = (left_w < LW'(size_reg)) ? S_DN_LB : S_DN_FIN;
            end
            S_DN_LB: begin
                pnode_next = ord_rdata;
                dist_raddr = ord_rdata;
                state_next = S_DN_LC;
            end
            S_DN_LC: begin
                if (dist_rdata < best_key_reg) begin
                    best_next      = IW'(left_w);
                    best_node_next = pnode_reg;
                    best_key_next  = dist_rdata;
                    moved_next     = 1'b1;
                end
                ord_raddr  = IW'(right_w);
                state_next = (right_w < LW'(size_reg)) ? S_DN_RB : S_DN_MV;
            end
            S_DN_RB: begin
                pnode_next = ord_rdata;
                dist_raddr = ord_rdata;
                state_next = S_DN_RC;
            end
            S_DN_RC: begin
                if (dist_rdata < best_key_reg) begin
                    best_next      = IW'(right_w);
                    best_node_next = pnode_reg;
                    best_key_next  = dist_rdata;
                    moved_next     = 1'b1;
                end
                state_next = S_DN_MV;
            end
            S_DN_MV: begin
                if (moved_reg) begin
                    ord_we = 1'b1; ord_waddr = slot_reg; ord_wdata = best_node_reg;
                    pos_we = 1'b1; pos_waddr = best_node_reg; pos_wdata = slot_reg;
                    slot_next  = best_reg;
                    state_next = S_DN_L;
                end else begin
                    state_next = S_DN_FIN;
                end
            end
            // Hand the result to the output register
            S_OUT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            size_reg  <= '0;
        end else begin
            state_reg <= state_next;
            size_reg  <= size_next;
        end
        cnt_reg       <= cnt_next;
        sweep_reg     <= sweep_next;
        slot_reg      <= slot_next;
        cur_node_reg  <= cur_node_next;
        cur_key_reg   <= cur_key_next;
        pnode_reg     <= pnode_next;
        best_reg      <= best_next;
        best_node_reg <= best_node_next;
        best_key_reg  <= best_key_next;
        moved_reg     <= moved_next;
        root_reg      <= root_next;
        node_reg      <= node_next;
        ndist_reg     <= ndist_next;
        res_reg       <= res_next;
    end

endmodule

[hdl/imhdk_checker.sv]
module imhdk_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [imhdk_pkg::NODE_W-1:0]  m_min_node,
    input logic                          m_found,
    input logic                          m_in_heap,
    input logic                          m_heap_empty,
    input logic                          m_status,
    input logic                          pready
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_min_node) && $stable(m_found)
                                && $stable(m_status) && $stable(m_heap_empty))
        else $error("stalled result changed");

    // One item in flight: ready drops after a transfer in
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while busy");

    // Result flags are exclusive per operation
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_found && m_status) && !(m_found && m_in_heap)
                    && !(m_in_heap && m_status))
        else $error("conflicting result flags");

    // Only an extract reports a node
    a_min_node: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_min_node == '0)
        else $error("min_node without found");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind indexed_min_heap_decrease_key_core imhdk_checker u_imhdk_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int NODES = 1024;
    localparam logic [31:0] DIST_INF = 32'hFFFF_FFFF;
    localparam logic [2:0] ADDR_NODE_COUNT = 3'd0;
    localparam logic [2:0] ADDR_SOURCE_NODE = 3'd4;

    typedef struct packed {
        logic [imhdk_pkg::FUNC_W-1:0]  func;
        logic [imhdk_pkg::NODE_W-1:0]  node;
        logic [imhdk_pkg::NDIST_W-1:0] new_dist;
    } heap_op_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [imhdk_pkg::FUNC_W-1:0]   s_func = '0;
    logic [imhdk_pkg::NODE_W-1:0]   s_node = '0;
    logic [imhdk_pkg::NDIST_W-1:0]  s_new_distance = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [imhdk_pkg::NODE_W-1:0]   m_min_node;
    logic                           m_found;
    logic                           m_in_heap;
    logic                           m_heap_empty;
    logic                           m_status;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [2:0]                     paddr = '0;
    logic [31:0]                    pwdata = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    indexed_min_heap_decrease_key_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func), .s_node(s_node),
        .s_new_distance(s_new_distance),
        .m_valid(m_valid), .m_ready(m_ready), .m_min_node(m_min_node),
        .m_found(m_found), .m_in_heap(m_in_heap), .m_heap_empty(m_heap_empty),
        .m_status(m_status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Shadow heap state
    logic [imhdk_pkg::NODE_W-1:0]  hp_order [NODES];
    logic [imhdk_pkg::NODE_W-1:0]  hp_pos   [NODES];
    logic [31:0]                   hp_dist  [NODES];
    int unsigned                   hp_size;
    logic [imhdk_pkg::COUNT_W-1:0] cfg_count;
    logic [imhdk_pkg::NODE_W-1:0]  cfg_source;

    heap_op_t           pending_ops[$];
    imhdk_pkg::result_t expected_results[$];
    int                 errors = 0;
    int                 send_idle_pct = 11;
    int                 recv_idle_pct = 71;
    bit                 recv_hold_on = 1'b0;
    bit                 send_paused = 1'b0;

    function automatic logic [31:0] key_of(int unsigned slot);
        return hp_dist[hp_order[slot]];
    endfunction

    function automatic void swap_heap_slots(int unsigned a, int unsigned b);
        logic [imhdk_pkg::NODE_W-1:0] na, nb;
        na = hp_order[a];
        nb = hp_order[b];
        hp_order[a] = nb;
        hp_order[b] = na;
        hp_pos[na] = a[imhdk_pkg::NODE_W-1:0] ^ a[imhdk_pkg::NODE_W-1:0] ^ b[imhdk_pkg::NODE_W-1:0];
        hp_pos[nb] = a[imhdk_pkg::NODE_W-1:0];
    endfunction

    function automatic void bubble_up(int unsigned slot);
        int unsigned parent;
        while (slot > 0) begin
            parent = (slot - 1) / 2;
            if (!(key_of(slot) < key_of(parent))) break;
            swap_heap_slots(slot, parent);
            slot = parent;
        end
    endfunction

    function automatic void bubble_down(int unsigned slot);
        int unsigned l, r, best;
        forever begin
            l = 2 * slot + 1;
            r = 2 * slot + 2;
            best = slot;
            if (l < hp_size && key_of(l) < key_of(best)) best = l;
            if (r < hp_size && key_of(r) < key_of(best)) best = r;
            if (best == slot) break;
            swap_heap_slots(best, slot);
            slot = best;
        end
    endfunction

    // Apply one operation to the shadow heap and return its result
    function automatic imhdk_pkg::result_t apply_heap_op(heap_op_t op);
        imhdk_pkg::result_t res;
        int unsigned cnt, last_slot;
        logic [imhdk_pkg::NODE_W-1:0] root, last;
        res = '0;
        case (op.func)
            imhdk_pkg::FUNC_INIT: begin
                cnt = cfg_count;
                if (cnt < 1) cnt = 1;
                if (cnt > NODES) cnt = NODES;
                for (int i = 0; i < NODES; i++) begin
                    hp_order[i] = i[imhdk_pkg::NODE_W-1:0];
                    hp_pos[i] = i[imhdk_pkg::NODE_W-1:0];
                    hp_dist[i] = DIST_INF;
                end
                hp_size = cnt;
                if (cfg_source < cnt) begin
                    hp_dist[cfg_source] = '0;
                    bubble_up(hp_pos[cfg_source]);
                end
            end
            imhdk_pkg::FUNC_EXTRACT: begin
                if (hp_size > 0) begin
                    last_slot = hp_size - 1;
                    root = hp_order[0];
                    last = hp_order[last_slot];
                    hp_order[0] = last;
                    hp_order[last_slot] = root;
                    hp_pos[root] = last_slot[imhdk_pkg::NODE_W-1:0];
                    hp_pos[last] = '0;
                    hp_size = last_slot;
                    bubble_down(0);
                    res.min_node = root;
                    res.found = 1'b1;
                end
            end
            imhdk_pkg::FUNC_DECREASE: begin
                if (hp_pos[op.node] < hp_size) begin
                    hp_dist[op.node] = op.new_dist;
                    bubble_up(hp_pos[op.node]);
                end else begin
                    res.status = 1'b1;
                end
            end
            default: begin
                res.in_heap = (hp_pos[op.node] < hp_size);
            end
        endcase
        res.heap_empty = (hp_size == 0);
        return res;
    endfunction

    // Driver: advance through pending ops, idling at random
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready) begin
                if (s_valid && s_ready)
                    expected_results.push_back(apply_heap_op({s_func, s_node, s_new_distance}));
                if (pending_ops.size() > 0 && !send_paused &&
                    $urandom_range(99) >= send_idle_pct) begin
                    heap_op_t op;
                    op = pending_ops.pop_front();
                    s_valid <= 1'b1;
                    s_func <= op.func;
                    s_node <= op.node;
                    s_new_distance <= op.new_dist;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result node=%0d found=%0b", $time,
                             m_min_node, m_found);
                    errors++;
                end else begin
                    imhdk_pkg::result_t want, got;
                    want = expected_results.pop_front();
                    got = {m_min_node, m_found, m_in_heap, m_heap_empty, m_status};
                    if (got.min_node !== want.min_node || got.found !== want.found ||
                        got.in_heap !== want.in_heap || got.heap_empty !== want.heap_empty ||
                        got.status !== want.status) begin
                        $display("%0t: mismatch expected node=%0d f=%0b ih=%0b e=%0b st=%0b",
                                 $time, want.min_node, want.found, want.in_heap,
                                 want.heap_empty, want.status);
                        $display("%0t:          actual   node=%0d f=%0b ih=%0b e=%0b st=%0b",
                                 $time, got.min_node, got.found, got.in_heap,
                                 got.heap_empty, got.status);
                        errors++;
                    end
                end
            end
            if (recv_hold_on) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic wait_idle();
        while (pending_ops.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(int unsigned cnt, int unsigned src);
        wait_idle();
        apb_write(ADDR_NODE_COUNT, cnt);
        apb_write(ADDR_SOURCE_NODE, src);
        cfg_count = cnt[imhdk_pkg::COUNT_W-1:0];
        cfg_source = src[imhdk_pkg::NODE_W-1:0];
    endtask

    function automatic void push_op(logic [imhdk_pkg::FUNC_W-1:0] f, int unsigned n,
                                    logic [31:0] d);
        heap_op_t op;
        op.func = f;
        op.node = n[imhdk_pkg::NODE_W-1:0];
        op.new_dist = d;
        pending_ops.push_back(op);
    endfunction

    function automatic logic [31:0] rand_distance();
        case ($urandom_range(5))
            0: return DIST_INF;
            1: return '0;
            2: return $urandom;
            default: return $urandom_range(300);
        endcase
    endfunction

    // A shortest-path style run: init, then a mix of decreases, queries and extracts
    task automatic queue_search(int unsigned cnt, int unsigned n_ops);
        int unsigned sel;
        push_op(imhdk_pkg::FUNC_INIT, $urandom_range(1023), $urandom);
        for (int i = 0; i < n_ops; i++) begin
            sel = $urandom_range(99);
            if (sel < 40)
                push_op(imhdk_pkg::FUNC_DECREASE, (sel < 37) ? $urandom_range(cnt - 1)
                        : $urandom_range(1023), rand_distance());
            else if (sel < 70)
                push_op(imhdk_pkg::FUNC_EXTRACT, $urandom_range(1023), $urandom);
            else
                push_op(imhdk_pkg::FUNC_QUERY, (sel < 90) ? $urandom_range(cnt - 1)
                        : $urandom_range(1023), $urandom);
        end
    endtask

    initial begin
        hp_size = 0;
        cfg_count = imhdk_pkg::NODE_COUNT_RST;
        cfg_source = imhdk_pkg::SOURCE_NODE_RST;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty heap before any initialize, then reset defaults
        push_op(imhdk_pkg::FUNC_EXTRACT, 0, 0);
        push_op(imhdk_pkg::FUNC_INIT, 0, 0);
        push_op(imhdk_pkg::FUNC_QUERY, 1023, 0);
        push_op(imhdk_pkg::FUNC_DECREASE, 1023, 32'd5);
        push_op(imhdk_pkg::FUNC_DECREASE, 5, 32'd5);
        push_op(imhdk_pkg::FUNC_DECREASE, 6, 32'd5);
        push_op(imhdk_pkg::FUNC_DECREASE, 7, DIST_INF);
        push_op(imhdk_pkg::FUNC_EXTRACT, 0, DIST_INF);
        push_op(imhdk_pkg::FUNC_EXTRACT, 0, 0);
        push_op(imhdk_pkg::FUNC_DECREASE, 0, 32'd1);
        push_op(imhdk_pkg::FUNC_QUERY, 0, 0);
        push_op(imhdk_pkg::FUNC_DECREASE, 6, 32'd9);

        // Tiny heap: count zero taken as one, drain to empty
        set_config(0, 0);
        push_op(imhdk_pkg::FUNC_INIT, 0, 0);
        push_op(imhdk_pkg::FUNC_EXTRACT, 0, 0);
        push_op(imhdk_pkg::FUNC_EXTRACT, 0, 0);
        push_op(imhdk_pkg::FUNC_QUERY, 0, 0);
        push_op(imhdk_pkg::FUNC_DECREASE, 0, 0);
        // Count above maximum clamps; source out of range keeps all infinite
        set_config(2047, 1023);
        push_op(imhdk_pkg::FUNC_INIT, 0, 0);
        push_op(imhdk_pkg::FUNC_EXTRACT, 0, 0);
        set_config(4, 9);
        push_op(imhdk_pkg::FUNC_INIT, 0, 0);
        push_op(imhdk_pkg::FUNC_DECREASE, 3, 32'd2);
        push_op(imhdk_pkg::FUNC_EXTRACT, 0, 0);
        push_op(imhdk_pkg::FUNC_QUERY, 3, 0);

        // Random searches across several settings
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 71 : 0;
            recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 11 : 0;
            for (int s = 0; s < 4; s++) begin
                int unsigned cnt;
                cnt = (s == 0 && phase == 2) ? 1024 : $urandom_range(2, 40);
                set_config(cnt, (s == 3) ? cnt - 1 : $urandom_range(cnt - 1));
                queue_search(cnt, 90);
            end
            if (phase == 1) begin
                // Stall the receiver long enough for the input to back up
                wait_idle();
                queue_search(8, 20);
                fork
                    begin
                        recv_hold_on = 1'b1;
                        repeat (300) @(posedge aclk);
                        recv_hold_on = 1'b0;
                    end
                join_none
                wait_idle();
                // Let every result drain before more traffic
                send_paused = 1'b1;
                queue_search(8, 10);
                repeat (20) @(posedge aclk);
                send_paused = 1'b0;
            end
        end

        wait_idle();
        repeat (100) @(posedge aclk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule
